@@ hdl/lz_word_compressor_near_far_macros.svh @@
// Assertion macros used by the compressor module.
`ifndef LZ_WORD_COMPRESSOR_NEAR_FAR_MACROS_SVH
`define LZ_WORD_COMPRESSOR_NEAR_FAR_MACROS_SVH

// Implication checked at every rising clock edge outside of reset.
`define LZC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define LZC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/lzc_pkg.sv @@
package lzc_pkg;
	localparam int HistoryWordsDefault = 4096;
	localparam int MaxCopyDefault      = 255;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_TOKEN   = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [2:0] KIND_PLAIN   = 3'd0;
	localparam logic [2:0] KIND_ESCAPED = 3'd1;
	localparam logic [2:0] KIND_NEAR    = 3'd2;
	localparam logic [2:0] KIND_FAR     = 3'd3;
	localparam logic [2:0] KIND_END     = 3'd4;

	localparam logic [7:0]  NEAR_TAG   = 8'hA7;
	localparam logic [7:0]  FAR_TAG    = 8'hA8;
	localparam logic [7:0]  NEAR_REACH = 8'd255;
	localparam logic [13:0] TOTAL_MAX  = 14'd16383;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  token_kind;
		logic [15:0] literal_word;
		logic [7:0]  copy_count;
		logic [11:0] copy_where;
		logic [2:0]  token_bytes;
		logic [13:0] total_bytes;
		logic        last;
	} out_item_t;
endpackage

@@ hdl/lzc_stream_if.sv @@
interface lzc_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/lzc_ram.sv @@
module lzc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/lz_word_compressor_near_far.sv @@
// Channel | Dir | Payload                                     | Transfer
// in_ch   | in  | operation, data_word                        | valid & ready
// out_ch  | out | kind, literal, count, where, bytes, total, last | valid & ready
//
// Loads and restarts are handled directly in the idle state. A token request
// first reads the current word and then reads each earlier start in turn. A start
// that matches the current word then compares further words one at a time, and
// each compare needs two reads. The single read port of the history memory
// makes all of these reads happen one after another.
// Reset clears all registers but not the history memory; history is unknown until loaded.
// A finished token waits in the output register. Loads and restarts are still
// taken, and a token request stalls only while that register is full and the
// pending token is not being taken in the same cycle.
`include "lz_word_compressor_near_far_macros.svh"

module lz_word_compressor_near_far #(
	parameter int HISTORY_WORDS = lzc_pkg::HistoryWordsDefault,
	parameter int MAX_COPY      = lzc_pkg::MaxCopyDefault
) (
	input logic clk,
	input logic arst_n,
	lzc_stream_if.sink   in_ch,
	lzc_stream_if.source out_ch
);
	localparam int AW = $clog2(HISTORY_WORDS);
	localparam int CW = AW + 1;

	// Sequencer states.
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CUR   = 4'd1;  // read the current word
	localparam logic [3:0] ST_CURW  = 4'd2;
	localparam logic [3:0] ST_SCAN  = 4'd3;  // read history[s]
	localparam logic [3:0] ST_SCANW = 4'd4;
	localparam logic [3:0] ST_MA    = 4'd5;  // read history[s+len]
	localparam logic [3:0] ST_MAW   = 4'd6;
	localparam logic [3:0] ST_MB    = 4'd7;  // read history[pos+len]
	localparam logic [3:0] ST_MBW   = 4'd8;
	localparam logic [3:0] ST_EMIT  = 4'd9;

	logic [3:0]    state_q;
	logic [CW-1:0] loaded_q, pos_q, s_q, best_q, best_at_q, len_q, cap_q;
	logic [13:0]   total_q;
	logic [15:0]   cur_q, a_q;
	logic          oval_q;
	lzc_pkg::out_item_t out_q;
	lzc_pkg::in_item_t  in_item;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [15:0]   rdata;

	assign in_item = in_ch.payload;
	assign in_ch.ready = (state_q == ST_IDLE) && !(oval_q && !out_ch.ready &&
		in_item.operation == lzc_pkg::OP_TOKEN);
	assign out_ch.valid = oval_q;
	assign out_ch.payload = out_q;

	lzc_ram #(.WIDTH(16), .DEPTH(HISTORY_WORDS)) u_hist (
		.clk(clk), .we(we), .waddr(waddr), .wdata(in_item.data_word),
		.raddr(raddr), .rdata(rdata)
	);

	logic in_xfer;
	assign in_xfer = in_ch.valid && in_ch.ready;
	assign we = in_xfer && in_item.operation == lzc_pkg::OP_LOAD &&
		loaded_q < CW'(HISTORY_WORDS);
	assign waddr = loaded_q[AW-1:0];

	always_comb begin
		case (state_q)
			ST_CUR:  raddr = pos_q[AW-1:0];
			ST_SCAN: raddr = s_q[AW-1:0];
			ST_MA:   raddr = AW'(s_q + len_q);
			ST_MB:   raddr = AW'(pos_q + len_q);
			default: raddr = pos_q[AW-1:0];
		endcase
	end

	// Match cap: min(pos - s, left, MAX_COPY).
	logic [CW-1:0] span, left, cap;
	always_comb begin
		span = pos_q - s_q;
		left = loaded_q - pos_q;
		cap = (span < left) ? span : left;
		if (cap > CW'(MAX_COPY)) begin
			cap = CW'(MAX_COPY);
		end
	end

	// Token decision from the finished search.
	lzc_pkg::out_item_t tok;
	logic [CW-1:0] adv, gap;
	logic [14:0]   sum;
	always_comb begin
		tok = '0;
		gap = pos_q - best_at_q;
		if (best_q > CW'(1) && gap <= CW'(lzc_pkg::NEAR_REACH)) begin
			tok.token_kind = lzc_pkg::KIND_NEAR;
			tok.copy_count = best_q[7:0];
			tok.copy_where = 12'(gap);
			tok.token_bytes = 3'd3;
			adv = best_q;
		end else if (best_q > CW'(2)) begin
			tok.token_kind = lzc_pkg::KIND_FAR;
			tok.copy_count = best_q[7:0];
			tok.copy_where = 12'(best_at_q);
			tok.token_bytes = 3'd4;
			adv = best_q;
		end else begin
			tok.literal_word = cur_q;
			if (cur_q[15:8] == lzc_pkg::NEAR_TAG || cur_q[15:8] == lzc_pkg::FAR_TAG) begin
				tok.token_kind = lzc_pkg::KIND_ESCAPED;
				tok.token_bytes = 3'd3;
			end else begin
				tok.token_kind = lzc_pkg::KIND_PLAIN;
				tok.token_bytes = 3'd2;
			end
			adv = CW'(1);
		end
		sum = {1'b0, total_q} + 15'(tok.token_bytes);
		tok.total_bytes = (sum > 15'(lzc_pkg::TOTAL_MAX)) ? lzc_pkg::TOTAL_MAX : sum[13:0];
		tok.last = (pos_q + adv) >= loaded_q;
	end

	// The token for a request that finds nothing left to encode.
	lzc_pkg::out_item_t end_tok;
	always_comb begin
		end_tok = '0;
		end_tok.token_kind = lzc_pkg::KIND_END;
		end_tok.total_bytes = total_q;
		end_tok.last = 1'b1;
	end

	// The output register is loaded either by an end token straight from idle
	// or by a finished search once the register is free or its token is being taken.
	logic end_load, emit_load;
	assign end_load = state_q == ST_IDLE && in_xfer &&
		in_item.operation == lzc_pkg::OP_TOKEN && pos_q >= loaded_q;
	assign emit_load = state_q == ST_EMIT && (!oval_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			loaded_q  <= '0;
			pos_q     <= '0;
			total_q   <= '0;
			oval_q    <= 1'b0;
			out_q     <= '0;
			s_q       <= '0;
			best_q    <= '0;
			best_at_q <= '0;
			len_q     <= '0;
			cap_q     <= '0;
			cur_q     <= '0;
			a_q       <= '0;
		end else begin
			if (end_load || emit_load) begin
				oval_q <= 1'b1;
			end else if (oval_q && out_ch.ready) begin
				oval_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						case (in_item.operation)
							lzc_pkg::OP_LOAD: begin
								if (we) begin
									loaded_q <= loaded_q + CW'(1);
								end
							end
							lzc_pkg::OP_RESTART: begin
								loaded_q <= '0;
								pos_q    <= '0;
								total_q  <= '0;
							end
							lzc_pkg::OP_TOKEN: begin
								if (pos_q >= loaded_q) begin
									out_q <= end_tok;
								end else begin
									best_q <= '0;
									best_at_q <= '0;
									s_q <= '0;
									state_q <= ST_CUR;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CUR:  state_q <= ST_CURW;
				ST_CURW: begin
					cur_q <= rdata;
					state_q <= ST_SCAN;
				end
				ST_SCAN: state_q <= (s_q < pos_q) ? ST_SCANW : ST_EMIT;
				ST_SCANW: begin
					if (rdata == cur_q) begin
						cap_q <= cap;
						len_q <= CW'(1);
						state_q <= ST_MA;
					end else begin
						s_q <= s_q + CW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_MA: begin
					if (len_q < cap_q) begin
						state_q <= ST_MAW;
					end else begin
						if (len_q >= best_q) begin
							best_q <= len_q;
							best_at_q <= s_q;
						end
						s_q <= s_q + CW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_MAW: begin
					a_q <= rdata;
					state_q <= ST_MB;
				end
				ST_MB:  state_q <= ST_MBW;
				ST_MBW: begin
					if (rdata == a_q) begin
						len_q <= len_q + CW'(1);
						state_q <= ST_MA;
					end else begin
						if (len_q >= best_q) begin
							best_q <= len_q;
							best_at_q <= s_q;
						end
						s_q <= s_q + CW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						out_q <= tok;
						total_q <= tok.total_bytes;
						pos_q <= pos_q + adv;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LZC_ASSERT_IMP(a_pos_le_loaded, clk, arst_n, 1'b1, pos_q <= loaded_q,
		"encode position beyond loaded words")
	`LZC_ASSERT_IMP(a_busy_not_ready, clk, arst_n, state_q != ST_IDLE, !in_ch.ready,
		"input taken during a search")
	`LZC_ASSERT_NEXT(a_out_hold, clk, arst_n, oval_q && !out_ch.ready, oval_q && $stable(out_q),
		"pending token changed")
	`LZC_ASSERT_IMP(a_best_cap, clk, arst_n, state_q == ST_EMIT, best_q <= CW'(MAX_COPY),
		"match longer than cap")
endmodule
